// ----- rtl/b32d_pkg.sv -----
// Shared types, codes and the character classifier for the base32 decoder.
package b32d_pkg;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;

  typedef enum logic [1:0] {
    ST_DECODING = 2'd0,
    ST_PADDED   = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_SYM = 2'd0,
    K_PAD = 2'd1,
    K_BAD = 2'd2
  } kind_t;

  // Classified character, front to back.
  typedef struct packed {
    kind_t      kind;
    logic [4:0] sym;
    logic       last;
  } cls_t;

  // One result item.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       end_of_string;
  } res_t;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit2 = 8'h32;
  localparam logic [7:0] ChDigit7 = 8'h37;
  localparam logic [7:0] ChPad    = 8'h3D;
  localparam logic [4:0] DigitBase = 5'd26;

  function automatic cls_t classify(input logic [7:0] c, input logic last);
    cls_t r;
    r.last = last;
    r.sym  = '0;
    r.kind = K_BAD;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r.kind = K_SYM;
      r.sym  = 5'(c - ChUpperA);
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      r.kind = K_SYM;
      r.sym  = 5'(c - ChLowerA);
    end else if (c >= ChDigit2 && c <= ChDigit7) begin
      r.kind = K_SYM;
      r.sym  = 5'(c - ChDigit2) + DigitBase;
    end else if (c == ChPad) begin
      r.kind = K_PAD;
    end
    return r;
  endfunction

endpackage

// ----- rtl/base32_decoder_core.sv -----
// Top level of the streaming base32 (RFC 4648) decoder.
//
//  channel | handshake      | payload
//  --------+----------------+-----------------------------------------------
//  input   | push / full    | char_code[7:0], last_char
//  result  | pop / empty    | byte_valid, data_byte[7:0], status[1:0],
//          |                | end_of_string
//
// One result item per input item, in order. Throughput is one item per cycle
// while neither side stalls; an accepted item is written into the classify
// queue, then the accumulator step writes its result into the result queue,
// from which it can be popped. The accumulator update is the only recurrence.
// rst is synchronous, active high; it empties both queues and clears the
// accumulator, bit count and status.
// Either side may stall: full rises only when the classify queue is full,
// which happens only when results back up through the result queue.
module base32_decoder_core #(
  parameter int unsigned MID_DEPTH = b32d_pkg::MidDepth,
  parameter int unsigned OUT_DEPTH = b32d_pkg::OutDepth
) (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  // result items
  output logic       empty,
  input  logic       pop,
  output logic       byte_valid,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       end_of_string
);

  // front -> back queue
  logic           mid_pop;
  logic           mid_empty;
  b32d_pkg::cls_t mid_data;

  // back -> result queue
  logic           out_push;
  logic           out_full;
  b32d_pkg::res_t out_data;
  logic [$bits(b32d_pkg::res_t)-1:0] res_raw;
  b32d_pkg::res_t res;

  // Classification of each character, buffered.
  b32d_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .mid_pop   (mid_pop),
    .mid_empty (mid_empty),
    .mid_data  (mid_data)
  );

  // Bit accumulator and status tracking.
  b32d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_data),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  // Result queue: decouples the accumulator from the consumer.
  b32d_fifo #(
    .W     ($bits(b32d_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_raw),
    .empty (empty)
  );

  assign res           = b32d_pkg::res_t'(res_raw);
  assign byte_valid    = res.byte_valid;
  assign data_byte     = res.data_byte;
  assign status        = res.status;
  assign end_of_string = res.end_of_string;

endmodule

// ----- rtl/b32d_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
module b32d_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/b32d_front.sv -----
// Front end: sorts each character into symbol, pad or bad and queues it.
module b32d_front #(
  parameter int unsigned MID_DEPTH = b32d_pkg::MidDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     char_code,
  input  logic           last_char,
  input  logic           mid_pop,
  output logic           mid_empty,
  output b32d_pkg::cls_t mid_data
);

  b32d_pkg::cls_t cls;
  logic [$bits(b32d_pkg::cls_t)-1:0] q_rdata;

  assign cls = b32d_pkg::classify(char_code, last_char);

  b32d_fifo #(
    .W     ($bits(b32d_pkg::cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (mid_pop),
    .rdata (q_rdata),
    .empty (mid_empty)
  );

  assign mid_data = b32d_pkg::cls_t'(q_rdata);

endmodule

// ----- rtl/b32d_back.sv -----
// Back end: bit accumulator, byte extraction and per-string status.
module b32d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_empty,
  input  b32d_pkg::cls_t mid_data,
  output logic           mid_pop,
  input  logic           out_full,
  output logic           out_push,
  output b32d_pkg::res_t out_data
);

  logic [11:0]       acc;
  logic [2:0]        held;
  b32d_pkg::status_t stat;

  logic [11:0]       acc_next;
  logic [2:0]        held_next;
  b32d_pkg::status_t stat_next;
  logic [3:0]        bits;
  logic [11:0]       acc_shift;
  logic              fire;

  assign fire     = !mid_empty && !out_full;
  assign mid_pop  = fire;
  assign out_push = fire;

  always_comb begin
    acc_shift = {acc[6:0], mid_data.sym};
    bits      = {1'b0, held} + 4'd5;
    acc_next  = acc;
    held_next = held;
    stat_next = stat;
    out_data.byte_valid = 1'b0;
    out_data.data_byte  = '0;
    if (stat == b32d_pkg::ST_DECODING) begin
      unique case (mid_data.kind)
        b32d_pkg::K_SYM: begin
          acc_next = acc_shift;
          if (bits >= 4'd8) begin
            bits = bits - 4'd8;
            out_data.byte_valid = 1'b1;
            out_data.data_byte  = 8'(acc_shift >> bits);
          end
          held_next = bits[2:0];
        end
        b32d_pkg::K_PAD: stat_next = b32d_pkg::ST_PADDED;
        default:         stat_next = b32d_pkg::ST_INVALID;
      endcase
    end
    out_data.status        = stat_next;
    out_data.end_of_string = mid_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
      stat <= b32d_pkg::ST_DECODING;
    end else if (fire) begin
      if (mid_data.last) begin
        acc  <= '0;
        held <= '0;
        stat <= b32d_pkg::ST_DECODING;
      end else begin
        acc  <= acc_next;
        held <= held_next;
        stat <= stat_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // End of string leaves a clean slate.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && mid_data.last |=> held == 3'd0 && stat == b32d_pkg::ST_DECODING
                              && acc == 12'd0)
    else $error("state not cleared after last character");

  // Bytes come only from a string still decoding.
  a_byte_decoding: assert property (@(posedge clk) disable iff (rst)
    fire && out_data.byte_valid |-> out_data.status == b32d_pkg::ST_DECODING)
    else $error("byte emitted outside decoding");

  // Once stopped, a string's status never changes until its end.
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    stat != b32d_pkg::ST_DECODING && !(fire && mid_data.last) |=> $stable(stat))
    else $error("stopped status changed mid-string");

  // No item moves back without a free output slot.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full && !mid_empty)
    else $error("back end moved an item without room");
`endif

endmodule
